/* hdl/fvde_pkg.sv */
// Shared types, character codes and helper functions for the form value decoder.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package fvde_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LG    = 8'h67;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_LM    = 8'h6D;
  localparam logic [7:0] CH_LP    = 8'h70;
  localparam logic [7:0] CH_LT_T  = 8'h74;
  // Offset from 'A' to its digit value 10.
  localparam logic [7:0] HEX_ALPHA_OFS = 8'd55;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    K_NONE = 3'd0,
    K_BYTE = 3'd1,
    K_TERM = 3'd2,
    K_LT   = 3'd3,
    K_GT   = 3'd4,
    K_AMP  = 3'd5
  } kind_t;

  // One classified request: optional literal prefix, then the main action.
  typedef struct packed {
    logic       pre_pct;
    logic       pre_held;
    logic [7:0] held;
    kind_t      kind;
    logic [7:0] data;
    logic       empty;
  } desc_t;

  typedef struct packed {
    logic  push;
    desc_t desc;
  } q_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h = '0;
    d = '0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      h.ok = 1'b1;
      h.val = d[3:0];
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - HEX_ALPHA_OFS;
      h.ok = 1'b1;
      h.val = d[3:0];
    end
    return h;
  endfunction

  function automatic logic [2:0] main_len(input kind_t k);
    logic [2:0] n;
    unique case (k)
      K_NONE:       n = 3'd0;
      K_BYTE:       n = 3'd1;
      K_TERM:       n = 3'd1;
      K_LT, K_GT:   n = 3'd4;
      K_AMP:        n = 3'd5;
      default:      n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] main_byte(input kind_t k, input logic [2:0] j,
                                           input logic [7:0] data);
    logic [7:0] b;
    b = CH_NUL;
    unique case (k)
      K_BYTE: b = data;
      K_LT, K_GT: begin
        unique case (j)
          3'd0:    b = CH_AMP;
          3'd1:    b = (k == K_LT) ? CH_LL : CH_LG;
          3'd2:    b = CH_LT_T;
          default: b = CH_SEMI;
        endcase
      end
      K_AMP: begin
        unique case (j)
          3'd0:    b = CH_AMP;
          3'd1:    b = CH_LA;
          3'd2:    b = CH_LM;
          3'd3:    b = CH_LP;
          default: b = CH_SEMI;
        endcase
      end
      default: b = CH_NUL;
    endcase
    return b;
  endfunction

endpackage

/* hdl/fvde_front.sv */
// Front end: accepts raw bytes, tracks the escape state and classifies each byte
// into a request for the back end where it yields one. Depends on fvde_pkg.
module fvde_front
  import fvde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  q_stat_t    q_stat,
  output q_push_t    q_push
);

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       seen_r, seen_nxt;
  logic       accept;
  desc_t      desc;
  hex_t       hex_b, hex_h;
  logic [7:0] dec_v;
  logic       plain;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign hex_b    = hex_decode(in_byte);
  assign hex_h    = hex_decode(held_r);
  assign dec_v    = {hex_h.val, hex_b.val};

  always_comb begin
    phase_nxt = PH_IDLE;
    held_nxt  = held_r;
    seen_nxt  = seen_r;
    desc      = '0;
    desc.held = held_r;
    desc.kind = K_NONE;
    plain     = 1'b1;

    unique case (phase_r)
      PH_PCT: begin
        if (hex_b.ok) begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIGIT;
          plain     = 1'b0;
        end else begin
          desc.pre_pct = 1'b1;
        end
      end
      PH_DIGIT: begin
        held_nxt = '0;
        if (hex_b.ok && hex_h.ok) begin
          plain = 1'b0;
          if (dec_v == CH_AMP) begin
            desc.kind = K_AMP;
          end else if (dec_v == CH_LT) begin
            desc.kind = K_LT;
          end else if (dec_v == CH_GT) begin
            desc.kind = K_GT;
          end else begin
            desc.kind = K_BYTE;
            desc.data = dec_v;
          end
        end else begin
          desc.pre_pct  = 1'b1;
          desc.pre_held = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (plain) begin
      if (in_byte == CH_AMP || in_byte == CH_NUL) begin
        desc.kind  = K_TERM;
        desc.empty = !seen_r;
        phase_nxt  = PH_IDLE;
        held_nxt   = '0;
        seen_nxt   = 1'b0;
      end else begin
        seen_nxt = 1'b1;
        if (in_byte == CH_PLUS) begin
          desc.kind = K_BYTE;
          desc.data = CH_SPACE;
        end else if (in_byte == CH_PCT) begin
          phase_nxt = PH_PCT;
        end else if (in_byte == CH_LT) begin
          desc.kind = K_LT;
        end else if (in_byte == CH_GT) begin
          desc.kind = K_GT;
        end else begin
          desc.kind = K_BYTE;
          desc.data = in_byte;
        end
      end
    end
  end

  assign q_push.push = accept && (desc.pre_pct || desc.kind != K_NONE);
  assign q_push.desc = desc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= '0;
      seen_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      seen_r  <= seen_nxt;
    end
  end

endmodule

/* hdl/fvde_queue.sv */
// Short request queue between the front and back ends.
// Register-based FIFO of desc_t entries; depends on fvde_pkg.
module fvde_queue
  import fvde_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_push_t q_push,
  input  logic    pop,
  output q_stat_t q_stat,
  output desc_t   head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  desc_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign q_stat.full  = (cnt_r == FULL_CNT);
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = q_push.push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.desc;
    end
  end

endmodule

/* hdl/fvde_back.sv */
// Back end: expands the request at the queue head into result bytes, one per
// cycle while out_stall is low, into the output register. Depends on fvde_pkg.
module fvde_back
  import fvde_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  q_stat_t    q_stat,
  input  desc_t      head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_empty_res
);

  logic [2:0] step_r, step_nxt;
  logic       valid_r;
  logic [7:0] byte_r;
  logic       last_r, empty_r;
  logic       load;
  logic [2:0] pre_n, total_n, j;
  logic [7:0] cur_byte;
  logic       cur_last;

  assign pre_n   = {2'b00, head.pre_pct} + {2'b00, head.pre_held};
  assign total_n = pre_n + main_len(head.kind);
  assign j       = step_r - pre_n;
  assign load    = !q_stat.empty && (!valid_r || !out_stall);
  assign pop     = load && (step_r == total_n - 3'd1);

  always_comb begin
    cur_last = 1'b0;
    if (head.pre_pct && step_r == 3'd0) begin
      cur_byte = CH_PCT;
    end else if (head.pre_held && step_r == 3'd1) begin
      cur_byte = head.held;
    end else begin
      cur_byte = main_byte(head.kind, j, head.data);
      cur_last = (head.kind == K_TERM);
    end
  end

  always_comb begin
    step_nxt = step_r;
    if (pop) begin
      step_nxt = '0;
    end else if (load) begin
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (load) begin
        valid_r <= 1'b1;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r  <= cur_byte;
      last_r  <= cur_last;
      empty_r <= cur_last && head.empty;
    end
  end

  assign out_valid     = valid_r;
  assign out_byte      = byte_r;
  assign out_last      = last_r;
  assign out_empty_res = empty_r;

endmodule

/* hdl/form_value_decode_escape_top.sv */
// Top level of the form value decoder: front end, request queue and back end.
// Depends on fvde_pkg, fvde_front, fvde_queue and fvde_back.
//
// Usage: raw bytes of a form field value enter on in_byte with in_valid; a byte
// is taken at a rising edge where in_valid is high and in_stall is low. A '&'
// or zero byte closes the field. Decoded, HTML-safe bytes leave on out_byte
// with out_valid; a result is taken where out_valid is high and out_stall low.
// The closing result carries out_byte zero and out_last; out_empty_res marks a
// field that held no value bytes.
// The first result of a byte is presented once the byte has passed the queue
// write and then the output register load.
// Throughput: one byte per cycle while each byte yields at most one result
// and out_stall is low. The back end emits one result per cycle while
// out_stall is low, so a byte that expands to more results (an entity such
// as &lt; or a failed escape) holds it longer; the queue of QDEPTH requests
// absorbs that and in_stall rises only when it is full. A '%' and the first
// digit of an escape yield no result. Reset clears the escape state, the
// queue pointers and output valid; no clearing pass is needed. A stalled
// receiver holds the output register, the queue fills and in_stall rises.
module form_value_decode_escape_top
  import fvde_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_empty_res
);

  q_push_t q_push;
  q_stat_t q_stat;
  desc_t   head;
  logic    pop;

  fvde_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .q_stat   (q_stat),
    .q_push   (q_push)
  );

  fvde_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .pop    (pop),
    .q_stat (q_stat),
    .head   (head)
  );

  fvde_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .out_empty_res (out_empty_res)
  );

`ifndef ASSERT_OFF
  // The front end must never push into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push.push && q_stat.full))
    else $error("request pushed into full queue");

  // A terminator result always carries a zero byte.
  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_byte == CH_NUL))
    else $error("terminator with nonzero byte");

  // The empty flag appears only on a terminator.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_empty_res) |-> out_last)
    else $error("empty flag without terminator");

  // The back end only pops a request when the queue holds one.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");
`endif

endmodule

/* test/tb_form_value_decode_escape_top.sv */
// Self-checking testbench for form_value_decode_escape_top: a directed table, then random fields.
// Every output byte is compared with an in-bench decoder/escaper model; depends on fvde_pkg.
module tb_form_value_decode_escape_top;
  import fvde_pkg::*;

  typedef struct packed {
    logic [7:0] b;
    logic       last;
    logic       empty;
  } out_char_t;

  // A raw input byte; when lit is set, its single result is given in res.
  typedef struct packed {
    logic [7:0] b;
    logic       lit;
    out_char_t  res;
  } raw_item_t;

  localparam int DIR_ROWS = 27;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_empty_res;

  raw_item_t raw_bytes[$];
  raw_item_t dir_table [0:DIR_ROWS-1];
  out_char_t expected_chars[$];
  out_char_t field_chars[$];

  // Decoder state mirrored by the bench.
  phase_t     esc_phase = PH_IDLE;
  logic [7:0] held_char = 8'h00;
  logic       field_started = 1'b0;

  int n_total = 0;
  int n_in_acc = 0;
  int n_out_chk = 0;
  int n_fields = 0;
  int n_decoded = 0;
  int n_err = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int quiet_cycles = 0;
  logic idle_ok;

  form_value_decode_escape_top u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .out_empty_res(out_empty_res)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Idling is on in windows of the run and off near its end.
  assign idle_ok = ((n_total - n_in_acc) > 60) && ((n_in_acc % 160) < 110);

  function automatic int hex_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
    if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] nib_char(input logic [3:0] n);
    return (n < 4'd10) ? CH_0 + 8'(n) : CH_UA + 8'(n - 4'd10);
  endfunction

  function automatic void emit(input logic [7:0] b, input logic last, input logic empty);
    out_char_t r;
    r.b = b;
    r.last = last;
    r.empty = empty;
    field_chars.push_back(r);
  endfunction

  function automatic void emit_html_safe(input logic [7:0] b);
    if (b == CH_LT || b == CH_GT) begin
      emit(CH_AMP, 1'b0, 1'b0);
      emit((b == CH_LT) ? CH_LL : CH_LG, 1'b0, 1'b0);
      emit(CH_LT_T, 1'b0, 1'b0);
      emit(CH_SEMI, 1'b0, 1'b0);
    end else begin
      emit(b, 1'b0, 1'b0);
    end
  endfunction

  // Works out the output bytes caused by one raw byte into field_chars.
  function automatic void decode_and_escape(input logic [7:0] b);
    int lo;
    int hi;
    logic [7:0] v;
    lo = hex_of(b);
    hi = hex_of(held_char);
    case (esc_phase)
      PH_PCT: begin
        if (lo >= 0) begin
          held_char = b;
          esc_phase = PH_DIGIT;
          return;
        end
        emit(CH_PCT, 1'b0, 1'b0);
        esc_phase = PH_IDLE;
      end
      PH_DIGIT: begin
        if (lo >= 0 && hi >= 0) begin
          v = 8'((hi << 4) | lo);
          esc_phase = PH_IDLE;
          held_char = 8'h00;
          n_decoded++;
          if (v == CH_AMP) begin
            emit(CH_AMP, 1'b0, 1'b0);
            emit(CH_LA, 1'b0, 1'b0);
            emit(CH_LM, 1'b0, 1'b0);
            emit(CH_LP, 1'b0, 1'b0);
            emit(CH_SEMI, 1'b0, 1'b0);
          end else begin
            emit_html_safe(v);
          end
          return;
        end
        // The escape broke on its second digit: both held characters go out as they are.
        emit(CH_PCT, 1'b0, 1'b0);
        emit(held_char, 1'b0, 1'b0);
        esc_phase = PH_IDLE;
        held_char = 8'h00;
      end
      default: esc_phase = PH_IDLE;
    endcase

    if (b == CH_AMP || b == CH_NUL) begin
      emit(CH_NUL, 1'b1, !field_started);
      esc_phase = PH_IDLE;
      held_char = 8'h00;
      field_started = 1'b0;
      n_fields++;
      return;
    end
    field_started = 1'b1;
    if (b == CH_PLUS) emit(CH_SPACE, 1'b0, 1'b0);
    else if (b == CH_PCT) esc_phase = PH_PCT;
    else emit_html_safe(b);
  endfunction

  function automatic void push_raw(input logic [7:0] b);
    raw_item_t it;
    it = '0;
    it.b = b;
    raw_bytes.push_back(it);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) begin
      c = CH_LA + 8'($urandom_range(0, 5));
    end else begin
      c = 8'($urandom_range(1, 255));
      while (hex_of(c) >= 0 || c == CH_AMP) c = 8'($urandom_range(1, 255));
    end
    return c;
  endfunction

  function automatic logic [7:0] pick_plain();
    logic [7:0] c;
    c = 8'($urandom_range(1, 255));
    while (c == CH_AMP || c == CH_PCT) c = 8'($urandom_range(1, 255));
    return c;
  endfunction

  // One random field: mostly well-formed escapes and text, some broken escapes and noise.
  function automatic void gen_field();
    int ntok;
    int k;
    logic [7:0] v;
    if ($urandom_range(0, 9) == 0) begin
      ntok = $urandom_range(1, 8);
      for (k = 0; k < ntok; k++) push_raw(8'($urandom_range(0, 255)));
    end else begin
      ntok = $urandom_range(0, 8);
      for (k = 0; k < ntok; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2: push_raw(pick_plain());
          3:       push_raw(CH_PLUS);
          4:       push_raw($urandom_range(0, 1) ? CH_LT : CH_GT);
          5, 6, 7: begin
            if ($urandom_range(0, 2) == 0) begin
              case ($urandom_range(0, 5))
                0:       v = CH_AMP;
                1:       v = CH_LT;
                2:       v = CH_GT;
                3:       v = CH_PLUS;
                4:       v = CH_NUL;
                default: v = 8'hFF;
              endcase
            end else begin
              v = 8'($urandom_range(0, 255));
            end
            push_raw(CH_PCT);
            push_raw(nib_char(v[7:4]));
            push_raw(nib_char(v[3:0]));
          end
          8: begin
            push_raw(CH_PCT);
            push_raw(pick_non_hex());
          end
          default: begin
            push_raw(CH_PCT);
            push_raw(nib_char(4'($urandom_range(0, 15))));
            push_raw(pick_non_hex());
          end
        endcase
      end
      // Sometimes leave an escape unfinished when the field closes.
      case ($urandom_range(0, 3))
        0: push_raw(CH_PCT);
        1: begin
          push_raw(CH_PCT);
          push_raw(nib_char(4'($urandom_range(0, 15))));
        end
        default: ;
      endcase
    end
    push_raw($urandom_range(0, 1) ? CH_AMP : CH_NUL);
  endfunction

  // Sender: a request that is stalled stays on the bus unchanged.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        field_chars.delete();
        decode_and_escape(raw_bytes[0].b);
        if (raw_bytes[0].lit) begin
          field_chars.delete();
          field_chars.push_back(raw_bytes[0].res);
        end
        foreach (field_chars[k]) expected_chars.push_back(field_chars[k]);
        void'(raw_bytes.pop_front());
        n_in_acc <= n_in_acc + 1;
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (raw_bytes.size() == 0) begin
        in_valid <= 1'b0;
      end else if (idle_ok && hold_left == 0 && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        gap_left <= $urandom_range(0, 11);
      end else begin
        in_valid <= 1'b1;
        in_byte <= raw_bytes[0].b;
      end
    end
  end

  // Receiver: random stall bursts plus one long hold that backs up the block.
  always @(posedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!hold_done && n_in_acc >= 120) begin
        out_stall <= 1'b1;
        hold_left <= 60;
        hold_done <= 1'b1;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (idle_ok && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 11);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_char_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected result: out_byte=%0h last=%0b empty_res=%0b",
               out_byte, out_last, out_empty_res);
        n_err++;
      end else begin
        e = expected_chars.pop_front();
        n_out_chk++;
        if (out_byte !== e.b) begin
          $error("out_byte: expected %0h, got %0h", e.b, out_byte);
          n_err++;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %0b, got %0b", e.last, out_last);
          n_err++;
        end
        if (out_empty_res !== e.empty) begin
          $error("out_empty_res: expected %0b, got %0b", e.empty, out_empty_res);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no request moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    // Results are typed in only for single-result rows that are obvious.
    dir_table = '{
      '{CH_NUL,            1'b1, '{CH_NUL,   1'b1, 1'b1}},
      '{CH_AMP,            1'b1, '{CH_NUL,   1'b1, 1'b1}},
      '{CH_PLUS,           1'b1, '{CH_SPACE, 1'b0, 1'b0}},
      '{8'hFF,             1'b1, '{8'hFF,    1'b0, 1'b0}},
      '{CH_LT,             1'b0, '0},
      '{CH_PCT,            1'b0, '0},
      '{CH_0 + 8'd2,       1'b0, '0},
      '{CH_0 + 8'd6,       1'b0, '0},
      '{CH_PCT,            1'b0, '0},
      '{CH_0 + 8'd3,       1'b0, '0},
      '{CH_UA + 8'd4,      1'b0, '0},
      '{CH_PCT,            1'b0, '0},
      '{CH_0 + 8'd2,       1'b0, '0},
      '{CH_UA + 8'd1,      1'b1, '{CH_PLUS,  1'b0, 1'b0}},
      '{CH_PCT,            1'b0, '0},
      '{CH_0,              1'b0, '0},
      '{CH_0,              1'b1, '{CH_NUL,   1'b0, 1'b0}},
      '{CH_PCT,            1'b0, '0},
      '{CH_LA,             1'b0, '0},
      '{CH_PCT,            1'b0, '0},
      '{CH_0 + 8'd4,       1'b0, '0},
      '{8'h7A,             1'b0, '0},
      '{CH_PCT,            1'b0, '0},
      '{CH_UA,             1'b0, '0},
      '{CH_AMP,            1'b0, '0},
      '{CH_PCT,            1'b0, '0},
      '{CH_NUL,            1'b0, '0}
    };
    for (int i = 0; i < DIR_ROWS; i++) raw_bytes.push_back(dir_table[i]);
    while (raw_bytes.size() < 470) gen_field();
    n_total = raw_bytes.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (n_in_acc < n_total) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d raw bytes closing %0d fields, %0d of them hex escapes;",
             n_total, n_fields, n_decoded);
    $display("checked %0d output bytes with %0d mismatches.", n_out_chk, n_err);
    if (n_err == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
